// File: sv/imu_fp_pkg.sv
// ============================================================================
// imu_fp_pkg
// Shared types and constants for the inertial sensor frame parser.
// ============================================================================
package imu_fp_pkg;

    // frame layout
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [3:0] POS_TYPE   = 4'd1;
    localparam logic [3:0] POS_FIRST  = 4'd2;
    localparam logic [3:0] POS_LAST   = 4'd10;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } imu_fp_kind_t;

    // field widths
    localparam int RAW_W  = 16;
    localparam int AXIS_W = 23;
    localparam int TEMP_W = 20;
    localparam int TQ_W   = 18;

    // scaling constants
    localparam logic signed [7:0]        RATE_MUL  = 8'sd125;
    localparam logic signed [7:0]        ANGLE_MUL = 8'sd45;
    // ceil(2^31 / 85): |raw| * 512 / 85 == (|raw| * TEMP_RECIP) >> 22
    localparam logic [24:0]              TEMP_RECIP = 25'd25264514;
    localparam int                       TEMP_SHIFT = 22;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 20'sd74240;

    // decoded frame handed from front to back
    typedef struct packed {
        imu_fp_kind_t            kind;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
        logic signed [RAW_W-1:0] raw_t;
    } imu_fp_frame_t;

endpackage

// File: sv/imu_fp_front.sv
// ============================================================================
// imu_fp_front
// Byte assembler: hunts for the header, collects the frame bytes and emits
// one decoded frame on the checksum byte when the type is known.
// ============================================================================
module imu_fp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             rx_byte,
    output logic                   push,
    output imu_fp_pkg::imu_fp_frame_t frame
);
    import imu_fp_pkg::*;

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] type_reg;
    logic [7:0] data_reg [0:7];
    logic [3:0] data_off;
    logic       type_ok;
    imu_fp_kind_t kind;

    // position tracking, out-of-range positions behave as the hunt state
    always_comb
    begin
        pos_next = pos_reg;
        if (pos_reg == 4'd0 || pos_reg > POS_LAST)
        begin
            pos_next = (rx_byte == HDR_BYTE) ? POS_TYPE : 4'd0;
        end
        else if (pos_reg < POS_LAST)
        begin
            pos_next = pos_reg + 4'd1;
        end
        else
        begin
            pos_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    // frame byte capture
    assign data_off = pos_reg - POS_FIRST;

    always_ff @(posedge clk)
    begin
        if (accept && pos_reg == POS_TYPE)
        begin
            type_reg <= rx_byte;
        end
        if (accept && pos_reg >= POS_FIRST && pos_reg < POS_LAST)
        begin
            data_reg[data_off[2:0]] <= rx_byte;
        end
    end

    // type decode
    always_comb
    begin
        type_ok = 1'b1;
        case (type_reg)
            TYPE_ACC:   kind = KIND_ACC;
            TYPE_RATE:  kind = KIND_RATE;
            TYPE_ANGLE: kind = KIND_ANGLE;
            default:
            begin
                kind    = KIND_ACC;
                type_ok = 1'b0;
            end
        endcase
    end

    // checksum byte closes the frame
    assign push        = accept && pos_reg == POS_LAST && type_ok;
    assign frame.kind  = kind;
    assign frame.raw_x = {data_reg[1], data_reg[0]};
    assign frame.raw_y = {data_reg[3], data_reg[2]};
    assign frame.raw_z = {data_reg[5], data_reg[4]};
    assign frame.raw_t = {data_reg[7], data_reg[6]};

endmodule

// File: sv/imu_fp_queue.sv
// ============================================================================
// imu_fp_queue
// Two-entry queue of decoded frames between the assembler and the scaler.
// ============================================================================
module imu_fp_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  imu_fp_pkg::imu_fp_frame_t wr_frame,
    output logic                      full,
    output logic                      rd_valid,
    input  logic                      pop,
    output imu_fp_pkg::imu_fp_frame_t rd_frame
);
    import imu_fp_pkg::*;

    imu_fp_frame_t entry_reg [0:1];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_pop;

    assign full     = count_reg == 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign do_pop   = pop && rd_valid;
    assign rd_frame = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_frame;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: sv/imu_fp_back.sv
// ============================================================================
// imu_fp_back
// Scaler: two-stage pipeline turning raw words into fixed point values,
// with the result held in the output register until taken.
// ============================================================================
module imu_fp_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  imu_fp_pkg::imu_fp_frame_t         in_frame,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output imu_fp_pkg::imu_fp_kind_t          out_kind,
    output logic signed [imu_fp_pkg::AXIS_W-1:0] out_x,
    output logic signed [imu_fp_pkg::AXIS_W-1:0] out_y,
    output logic signed [imu_fp_pkg::AXIS_W-1:0] out_z,
    output logic signed [imu_fp_pkg::TEMP_W-1:0] out_temp
);
    import imu_fp_pkg::*;

    // raw word times the kind's multiplier (angle still needs its /4)
    function automatic logic signed [AXIS_W-1:0] axis_mul(
        input imu_fp_kind_t            k,
        input logic signed [RAW_W-1:0] raw
    );
        logic signed [RAW_W+7:0] prod;
        begin
            case (k)
                KIND_RATE:  prod = raw * RATE_MUL;
                KIND_ANGLE: prod = raw * ANGLE_MUL;
                default:    prod = (RAW_W+8)'(raw);
            endcase
            axis_mul = prod[AXIS_W-1:0];
        end
    endfunction

    logic                     s1_valid_reg;
    imu_fp_kind_t             s1_kind_reg;
    logic signed [AXIS_W-1:0] s1_x_reg;
    logic signed [AXIS_W-1:0] s1_y_reg;
    logic signed [AXIS_W-1:0] s1_z_reg;
    logic [TQ_W-1:0]          s1_tq_reg;
    logic                     s1_tneg_reg;

    logic                     out_valid_reg;
    imu_fp_kind_t             out_kind_reg;
    logic signed [AXIS_W-1:0] out_x_reg;
    logic signed [AXIS_W-1:0] out_y_reg;
    logic signed [AXIS_W-1:0] out_z_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;

    logic                     adv2;
    logic                     adv1;
    logic [RAW_W-1:0]         t_mag;
    logic [RAW_W+24:0]        t_prod;
    logic signed [TEMP_W-1:0] t_q;
    logic signed [TEMP_W-1:0] t_signed;

    // pipeline advance
    assign adv2     = !out_valid_reg || out_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    // temperature magnitude times reciprocal of 85
    assign t_mag  = in_frame.raw_t[RAW_W-1] ? (~in_frame.raw_t + 16'd1) : in_frame.raw_t;
    assign t_prod = t_mag * TEMP_RECIP;

    // stage 1: multiplies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_kind_reg <= in_frame.kind;
            s1_x_reg    <= axis_mul(in_frame.kind, in_frame.raw_x);
            s1_y_reg    <= axis_mul(in_frame.kind, in_frame.raw_y);
            s1_z_reg    <= axis_mul(in_frame.kind, in_frame.raw_z);
            s1_tq_reg   <= t_prod[TEMP_SHIFT+TQ_W-1:TEMP_SHIFT];
            s1_tneg_reg <= in_frame.raw_t[RAW_W-1];
        end
    end

    // stage 2: angle floor, temperature sign and offset
    assign t_q      = {{(TEMP_W-TQ_W){1'b0}}, s1_tq_reg};
    assign t_signed = (s1_tneg_reg ? -t_q : t_q) + TEMP_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            out_kind_reg <= s1_kind_reg;
            if (s1_kind_reg == KIND_ANGLE)
            begin
                out_x_reg <= s1_x_reg >>> 2;
                out_y_reg <= s1_y_reg >>> 2;
                out_z_reg <= s1_z_reg >>> 2;
            end
            else
            begin
                out_x_reg <= s1_x_reg;
                out_y_reg <= s1_y_reg;
                out_z_reg <= s1_z_reg;
            end
            out_temp_reg <= t_signed;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_temp  = out_temp_reg;

endmodule

// File: sv/imu_frame_parser.sv
// ============================================================================
// imu_frame_parser
// Parser for 11-byte inertial sensor UART frames, fixed point results.
// ============================================================================
// Usage:
//   s_* carries received serial bytes, one item per byte. The parser waits
//   for the 0x55 header, collects type, four little-endian words and the
//   checksum (not checked). A frame of type 0x51, 0x52 or 0x53 gives one
//   item on m_*: m_tuser holds the kind, m_tdata the x, y, z values and the
//   temperature, all signed with 11 fraction bits. Other types give nothing.
// Throughput: one byte per cycle while the frame queue is not full.
// Path: after the checksum byte is taken, the result passes the queue
//   entry, the multiply stage and the output register.
// Stalls: the result is held in the output register until m_tready; the
//   scaler pipeline and a two-entry frame queue absorb the stall, and
//   s_tready drops only while that queue is full.
// Reset: position returns to header hunt, queue and pipeline empty. The
//   frame bytes are not cleared, every byte is written before use.
// ============================================================================
module imu_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [22:0] axis_x, [45:23] axis_y, [68:46] axis_z,
                                   // [88:69] temperature, [95:89] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import imu_fp_pkg::*;

    logic                     accept;
    logic                     push;
    logic                     q_full;
    logic                     q_valid;
    logic                     q_pop;
    imu_fp_frame_t            front_frame;
    imu_fp_frame_t            q_frame;
    imu_fp_kind_t             out_kind;
    logic signed [AXIS_W-1:0] out_x;
    logic signed [AXIS_W-1:0] out_y;
    logic signed [AXIS_W-1:0] out_z;
    logic signed [TEMP_W-1:0] out_temp;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // byte assembler
    imu_fp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .push    (push),
        .frame   (front_frame)
    );

    // frame queue
    imu_fp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_frame (front_frame),
        .full     (q_full),
        .rd_valid (q_valid),
        .pop      (q_pop),
        .rd_frame (q_frame)
    );

    // scaler
    imu_fp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_frame  (q_frame),
        .in_ready  (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_temp  (out_temp)
    );

    // output packing
    assign m_tuser = out_kind;
    assign m_tdata = {7'd0, out_temp, out_z, out_y, out_x};

endmodule

// File: sv/imu_fp_checker.sv
// ============================================================================
// imu_fp_checker
// Port-level checks for the frame parser, bound to the top level.
// ============================================================================
module imu_fp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import imu_fp_pkg::*;

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // kind is a known code and padding is clear
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_ACC || m_tuser == KIND_RATE ||
                      m_tuser == KIND_ANGLE) && m_tdata[95:89] == 7'd0)
        else $error("bad kind or padding");

    // acceleration is the raw word, sign extended
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_ACC |->
            (m_tdata[22:15] == 8'h00 || m_tdata[22:15] == 8'hFF))
        else $error("acceleration out of raw range");

    // temperature inside its span
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[88:69]) >= -20'sd123139 &&
                     $signed(m_tdata[88:69]) <= 20'sd271615)
        else $error("temperature out of range");

endmodule

bind imu_frame_parser imu_fp_checker u_imu_fp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
